### hdl/hse_pkg.sv
// Shared types and constants for the heap sort engine.
// No dependencies; compiled before every other file of the block.
package hse_pkg;

  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SIFT_RD,
    S_SIFT_HV,
    S_CHILD,
    S_LEFT,
    S_RIGHT,
    S_CMP,
    S_SIFT_END,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_OUT_RD,
    S_OUT_LOAD,
    S_OUT_HOLD
  } state_t;

endpackage

### hdl/hse_in_if.sv
// Input channel of the heap sort engine: one value per transaction and a last flag.
// Depends on hse_pkg.
interface hse_in_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, value, last_item, input ready);
  modport sink (input valid, value, last_item, output ready);
endinterface

### hdl/hse_out_if.sv
// Result channel of the heap sort engine: one sorted value per transaction.
// Depends on hse_pkg.
interface hse_out_if import hse_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_result;

  modport source (output valid, sorted_value, last_result, input ready);
  modport sink (input valid, sorted_value, last_result, output ready);
endinterface

### hdl/hse_ram.sv
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module hse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/heap_sort_engine_unit.sv
// Top level of the heap sort engine: load sequencer, heap sort sequencer and result stage.
// Depends on hse_pkg, hse_in_if, hse_out_if and hse_ram.
//
// The block takes one signed value per transaction into its store and ignores values
// beyond MAX_ITEMS. The transaction that carries last_item closes the set: the block
// builds a max-heap, sorts the set in place and returns every stored value in ascending
// order, with last_result high on the largest. It takes no input from that transaction
// until the last result has been taken. All compares go through one comparator fed by
// the store's single read port.
module heap_sort_engine_unit import hse_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic       clk,
  input  logic       rst,
  hse_in_if.sink     items,
  hse_out_if.source  results
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int IW = CW + 1;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] n_items;
  logic [CW-1:0] hsize;
  logic [CW-1:0] k;
  logic [CW-1:0] idx;
  logic [AW-1:0] node;
  logic [AW-1:0] ci;
  logic          building;
  data_t         hv;
  data_t         cv;
  data_t         out_value;
  logic          out_valid;
  logic          out_last;

  logic          accept;
  logic          full;
  logic [CW-1:0] n_eff;
  logic [IW-1:0] kid;
  logic [IW-1:0] kid_r;
  logic          has_kid;
  logic          has_r;
  data_t         cmp_a;
  data_t         cmp_b;
  logic          gt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  data_t         wr_data;
  logic [AW-1:0] rd_addr;
  data_t         rd_data;

  assign accept  = items.valid && items.ready;
  assign full    = (count == CW'(MAX_ITEMS));
  assign n_eff   = full ? count : count + CW'(1);
  assign kid     = (IW'(node) << 1) | IW'(1);
  assign kid_r   = kid + IW'(1);
  assign has_kid = kid < IW'(hsize);
  assign has_r   = kid_r < IW'(hsize);

  // The one comparator serves both the child pick and the compare against the held value.
  assign cmp_a = (state == S_RIGHT) ? rd_data : cv;
  assign cmp_b = (state == S_RIGHT) ? cv : hv;
  assign gt    = cmp_a > cmp_b;

  assign items.ready          = (state == S_IDLE);
  assign results.valid        = out_valid;
  assign results.sorted_value = out_value;
  assign results.last_result  = out_last;

  hse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && items.last_item) begin
          if (n_eff >= CW'(2)) begin
            state_next = S_SIFT_RD;
          end else if (n_eff == CW'(1)) begin
            state_next = S_OUT_RD;
          end
        end
      end
      S_SIFT_RD:  state_next = S_SIFT_HV;
      S_SIFT_HV:  state_next = S_CHILD;
      S_CHILD:    state_next = has_kid ? S_LEFT : S_SIFT_END;
      S_LEFT:     state_next = has_r ? S_RIGHT : S_CMP;
      S_RIGHT:    state_next = S_CMP;
      S_CMP:      state_next = gt ? S_CHILD : S_SIFT_END;
      S_SIFT_END: begin
        if (building) begin
          state_next = (k > CW'(1)) ? S_SIFT_RD : S_SWAP_A;
        end else begin
          state_next = (k == CW'(1)) ? S_OUT_RD : S_SWAP_A;
        end
      end
      S_SWAP_A:   state_next = S_SWAP_B;
      S_SWAP_B:   state_next = S_SWAP_C;
      S_SWAP_C:   state_next = S_CHILD;
      S_OUT_RD:   state_next = S_OUT_LOAD;
      S_OUT_LOAD: state_next = S_OUT_HOLD;
      S_OUT_HOLD: begin
        if (results.ready) begin
          state_next = out_last ? S_IDLE : S_OUT_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = node;
    wr_data = hv;
    rd_addr = node;
    unique case (state)
      S_IDLE: begin
        wr_en   = accept && !full;
        wr_addr = count[AW-1:0];
        wr_data = items.value;
      end
      S_CHILD: begin
        wr_en   = !has_kid;
        rd_addr = kid[AW-1:0];
      end
      S_LEFT:   rd_addr = kid_r[AW-1:0];
      S_CMP: begin
        wr_en   = 1'b1;
        wr_data = gt ? cv : hv;
      end
      S_SWAP_A: rd_addr = '0;
      S_SWAP_B: rd_addr = k[AW-1:0];
      S_SWAP_C: begin
        wr_en   = 1'b1;
        wr_addr = k[AW-1:0];
        wr_data = cv;
      end
      S_OUT_RD: rd_addr = idx[AW-1:0];
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      building  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (items.last_item) begin
              count    <= '0;
              n_items  <= n_eff;
              hsize    <= n_eff;
              k        <= n_eff >> 1;
              node     <= AW'((n_eff >> 1) - CW'(1));
              building <= 1'b1;
              idx      <= '0;
            end else if (!full) begin
              count <= count + CW'(1);
            end
          end
        end
        S_SIFT_HV: hv <= rd_data;
        S_LEFT: begin
          cv <= rd_data;
          ci <= kid[AW-1:0];
        end
        S_RIGHT: begin
          if (gt) begin
            cv <= rd_data;
            ci <= kid_r[AW-1:0];
          end
        end
        S_CMP: begin
          if (gt) begin
            node <= ci;
          end
        end
        S_SIFT_END: begin
          if (building) begin
            if (k > CW'(1)) begin
              k    <= k - CW'(1);
              node <= AW'(k - CW'(2));
            end else begin
              building <= 1'b0;
              k        <= n_items - CW'(1);
            end
          end else if (k != CW'(1)) begin
            k <= k - CW'(1);
          end
        end
        S_SWAP_B: cv <= rd_data;
        S_SWAP_C: begin
          hv    <= rd_data;
          node  <= '0;
          hsize <= k;
        end
        S_OUT_LOAD: begin
          out_value <= rd_data;
          out_last  <= (idx == n_items - CW'(1));
          out_valid <= 1'b1;
        end
        S_OUT_HOLD: begin
          if (results.ready) begin
            out_valid <= 1'b0;
            idx       <= idx + CW'(1);
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (IW'(wr_addr) < IW'(MAX_ITEMS)))
    else $error("Store write beyond capacity.");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("Item count exceeds capacity.");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    items.ready |-> !results.valid)
    else $error("Input taken while a result is pending.");

  a_result_state: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (state == S_OUT_HOLD))
    else $error("Result shown outside the output state.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.last_result) |=> (items.ready && count == '0))
    else $error("Block not ready for a new set after the last transaction.");

endmodule
